@@ sv/pwpf_pkg.sv @@
// pwpf_pkg: shared widths, constants and types for the plane-wave phase factor block.
// The arctangent table and the pipeline data bundle live here.
// No dependencies.
package pwpf_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int CORDIC_STAGES   = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int CORDIC_CELLS    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int IDX_W           = 5;

  localparam int COORD_W = 32;
  localparam int SUM_W   = COORD_W + 1;
  localparam int PROD_W  = 64;
  localparam int TURN_W  = 32;
  localparam int XY_W    = 34;
  localparam int ANG_W   = 33;
  localparam int OUT_W   = 16;
  localparam int CFG_IDX_W = 2;

  // bring the dot product to 32 fraction bits
  localparam int DBL_FRAC = 2 * COORD_FRAC_BITS;
  localparam int SHR_AMT  = (DBL_FRAC >= 32) ? (DBL_FRAC - 32) : 0;
  localparam int SHL_AMT  = (DBL_FRAC >= 32) ? 0 : (32 - DBL_FRAC);

  localparam logic [29:0]       INV_TWO_PI_Q32  = 30'd683565276;
  localparam logic [XY_W-1:0]   CORDIC_GAIN_Q30 = XY_W'(652032874);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHIFT_X = 2'd0,
    CFG_SHIFT_Y = 2'd1,
    CFG_SHIFT_Z = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] a;
    logic                    neg;
  } cordic_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [ANG_W-1:0] atan_turn(input logic [IDX_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return $signed({{(ANG_W-30){1'b0}}, v});
  endfunction

endpackage

@@ sv/pwpf_phase.sv @@
// pwpf_phase: front pipeline, shift add, dot product, turn scaling and quadrant fold.
// Five register stages, all advancing on en.
// Depends on pwpf_pkg.
module pwpf_phase (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    shift_x,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    shift_y,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    shift_z,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    lattice_x,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    lattice_y,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    lattice_z,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    point_x,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    point_y,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    point_z,
  output logic                                   out_valid,
  output pwpf_pkg::cordic_t                      out_data
);
  import pwpf_pkg::*;

  logic [4:0] vld_r;

  // stage 1: shifted lattice vector
  logic signed [SUM_W-1:0]   gx_r, gy_r, gz_r;
  logic signed [COORD_W-1:0] rx_r, ry_r, rz_r;
  // stage 2: products
  logic signed [2*COORD_W:0] prx, pry, prz;
  logic signed [PROD_W-1:0]  px_r, py_r, pz_r;
  // stage 3: scaled dot product
  logic signed [PROD_W-1:0]  dot, scaled;
  logic [PROD_W-1:0]         p_r;
  // stage 4: partial products of the turn scaling
  logic [61:0]               lo_prod;
  logic [61:0]               hi_prod;
  logic [TURN_W-1:0]         lo_hi_r, hi_lo_r;
  // stage 5: fold
  logic [TURN_W-1:0]         turn;
  logic signed [ANG_W-1:0]   ang, ang_fold;
  logic                      fold;
  cordic_t                   data_r;

  assign prx = gx_r * rx_r;
  assign pry = gy_r * ry_r;
  assign prz = gz_r * rz_r;

  assign dot    = px_r + py_r + pz_r;
  assign scaled = (dot >>> SHR_AMT) <<< SHL_AMT;

  assign lo_prod = p_r[31:0] * INV_TWO_PI_Q32;
  assign hi_prod = p_r[63:32] * INV_TWO_PI_Q32;

  // only bits 63..32 of the 64-bit product matter
  assign turn = lo_hi_r + hi_lo_r;
  assign ang  = $signed({turn[TURN_W-1], turn});

  always_comb begin
    fold     = 1'b0;
    ang_fold = ang;
    if (ang > $signed(ANG_W'(1 << 30))) begin
      fold     = 1'b1;
      ang_fold = ang - $signed(ANG_W'(33'h0_8000_0000));
    end else if (ang < -$signed(ANG_W'(1 << 30))) begin
      fold     = 1'b1;
      ang_fold = ang + $signed(ANG_W'(33'h0_8000_0000));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r <= $signed({lattice_x[COORD_W-1], lattice_x}) + $signed({shift_x[COORD_W-1], shift_x});
      gy_r <= $signed({lattice_y[COORD_W-1], lattice_y}) + $signed({shift_y[COORD_W-1], shift_y});
      gz_r <= $signed({lattice_z[COORD_W-1], lattice_z}) + $signed({shift_z[COORD_W-1], shift_z});
      rx_r <= point_x;
      ry_r <= point_y;
      rz_r <= point_z;

      px_r <= prx[PROD_W-1:0];
      py_r <= pry[PROD_W-1:0];
      pz_r <= prz[PROD_W-1:0];

      p_r <= scaled;

      lo_hi_r <= {2'b00, lo_prod[61:32]};
      hi_lo_r <= hi_prod[31:0];

      data_r.x   <= CORDIC_GAIN_Q30;
      data_r.y   <= '0;
      data_r.a   <= ang_fold;
      data_r.neg <= fold;
    end
  end

  assign out_valid = vld_r[4];
  assign out_data  = data_r;

endmodule

@@ sv/pwpf_cordic_cell.sv @@
// pwpf_cordic_cell: one rotation-mode CORDIC iteration with its own output register.
// The stage index is tied to a constant at the instance.
// Depends on pwpf_pkg.
module pwpf_cordic_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [pwpf_pkg::IDX_W-1:0]   stage_idx,
  input  logic                         in_valid,
  input  pwpf_pkg::cordic_t            in_data,
  output logic                         out_valid,
  output pwpf_pkg::cordic_t            out_data
);
  import pwpf_pkg::*;

  logic                    valid_r;
  cordic_t                 data_r, data_nxt;
  logic signed [XY_W-1:0]  xs, ys;
  logic signed [ANG_W-1:0] at;
  logic                    dir;

  assign xs  = in_data.x >>> stage_idx;
  assign ys  = in_data.y >>> stage_idx;
  assign at  = atan_turn(stage_idx);
  assign dir = (in_data.a >= 0);

  always_comb begin
    data_nxt.neg = in_data.neg;
    if (dir) begin
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
      data_nxt.a = in_data.a - at;
    end else begin
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
      data_nxt.a = in_data.a + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ sv/plane_wave_phase_factor.sv @@
// plane_wave_phase_factor: top level, config registers, cell chain, rounding and output skid.
// Depends on pwpf_pkg, pwpf_phase and pwpf_cordic_cell.
//
// Usage: each input beat (in_valid, in_stall) carries a lattice vector and a point,
// all signed Q15.16. The config channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes shift_x/y/z; cfg_ready is always high and unknown indexes are dropped.
// Write config only while the pipeline is empty.
// Each accepted beat yields one output beat (out_valid, out_stall) with cos_part and
// sin_part in Q1.14, in order.
// Path from input beat to out_valid: 5 front stages, 16 CORDIC cells,
// one output register. Throughput: one beat per cycle while in_stall is low, set by the fully
// pipelined front end and the CORDIC cell chain.
// When the receiver stalls, the output register holds and one more beat lands in the
// skid register; in_stall rises the cycle after and the whole pipeline freezes.
// in_stall is registered and does not depend combinationally on out_stall.
// Reset clears the shift registers to zero and empties every stage.
module plane_wave_phase_factor (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pwpf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pwpf_pkg::COORD_W-1:0]           cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    in_lattice_x,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    in_lattice_y,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    in_lattice_z,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    in_point_x,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    in_point_y,
  input  logic signed [pwpf_pkg::COORD_W-1:0]    in_point_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pwpf_pkg::OUT_W-1:0]      out_cos_part,
  output logic signed [pwpf_pkg::OUT_W-1:0]      out_sin_part
);
  import pwpf_pkg::*;

  logic signed [COORD_W-1:0] shift_x_r, shift_y_r, shift_z_r;
  logic                      en;

  logic                      chain_valid [0:CORDIC_CELLS];
  cordic_t                   chain_data  [0:CORDIC_CELLS];

  logic                      out_valid_r, skid_valid_r;
  logic signed [OUT_W-1:0]   out_cos_r, out_sin_r, skid_cos_r, skid_sin_r;
  logic signed [OUT_W-1:0]   res_cos, res_sin;
  logic                      arrive;

  // round half up to 14 fraction bits, apply fold sign, clamp to +-1
  function automatic logic signed [OUT_W-1:0] finish(input logic signed [XY_W-1:0] v,
                                                     input logic neg);
    logic signed [XY_W:0]    rnd;
    logic signed [XY_W-16:0] r;
    rnd = $signed({v[XY_W-1], v}) + $signed((XY_W+1)'(32768));
    r   = rnd[XY_W:16];
    if (neg) begin
      r = -r;
    end
    if (r > $signed((XY_W-15)'(16384))) begin
      r = (XY_W-15)'(16384);
    end else if (r < -$signed((XY_W-15)'(16384))) begin
      r = -$signed((XY_W-15)'(16384));
    end
    return r[OUT_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SHIFT_X: shift_x_r <= cfg_data;
        CFG_SHIFT_Y: shift_y_r <= cfg_data;
        CFG_SHIFT_Z: shift_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline freezes once the skid register holds a beat
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  pwpf_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .shift_x   (shift_x_r),
    .shift_y   (shift_y_r),
    .shift_z   (shift_z_r),
    .lattice_x (in_lattice_x),
    .lattice_y (in_lattice_y),
    .lattice_z (in_lattice_z),
    .point_x   (in_point_x),
    .point_y   (in_point_y),
    .point_z   (in_point_z),
    .out_valid (chain_valid[0]),
    .out_data  (chain_data[0])
  );

  for (genvar i = 0; i < CORDIC_CELLS; i++) begin : g_cell
    pwpf_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .stage_idx (IDX_W'(i)),
      .in_valid  (chain_valid[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  assign res_cos = finish(chain_data[CORDIC_CELLS].x, chain_data[CORDIC_CELLS].neg);
  assign res_sin = finish(chain_data[CORDIC_CELLS].y, chain_data[CORDIC_CELLS].neg);
  assign arrive  = en && chain_valid[CORDIC_CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= arrive;
      end
    end else if (arrive) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_cos_r <= skid_cos_r;
        out_sin_r <= skid_sin_r;
      end else begin
        out_cos_r <= res_cos;
        out_sin_r <= res_sin;
      end
    end else if (arrive) begin
      skid_cos_r <= res_cos;
      skid_sin_r <= res_sin;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cos_part = out_cos_r;
  assign out_sin_part = out_sin_r;

  // skid only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall && chain_valid[CORDIC_CELLS]))
    else $error("skid filled without a stalled output and an arriving beat");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> $past(en))
    else $error("input beat accepted while pipeline frozen");

  a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && $past(!en)) |-> $stable(chain_valid[CORDIC_CELLS]))
    else $error("cell chain moved while frozen");

endmodule
